FILE: rtl/core/bvmon_pkg.sv
`timescale 1ns / 1ps

package bvmon_pkg;

  localparam int unsigned VoltW    = 16;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // |slope * (sample - ref)| stays below 2^28
  localparam int unsigned ProdW    = 29;
  localparam int unsigned ProdMagW = 28;
  localparam int unsigned CalDiv   = 100;

  // floor(m * CalRecip / 2^CalShift) == m / 100 for every m below 2^28
  localparam int unsigned CalRecip  = 42949673;
  localparam int unsigned CalRecipW = 26;
  localparam int unsigned CalShift  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOPE_X100      = 3'd0,
    REG_ADC_REF         = 3'd1,
    REG_VOLT_REF        = 3'd2,
    REG_USB_LEVEL       = 3'd3,
    REG_SUPER_LOW_LEVEL = 3'd4,
    REG_LOW_LEVEL       = 3'd5
  } cfg_reg_e;

  typedef enum logic [LevelW-1:0] {
    LVL_USB       = 2'd0,
    LVL_SUPER_LOW = 2'd1,
    LVL_LOW       = 2'd2,
    LVL_OK        = 2'd3
  } level_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic cal_start;
    logic cal_done;
    logic update;
    logic mean_start;
    logic out_load;
  } dp_cmd_t;

endpackage

FILE: rtl/core/bvmon_div.sv
`timescale 1ns / 1ps

module bvmon_div #(
  parameter int unsigned DvdW = 28,
  parameter int unsigned DsrW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DsrW:0]   rem_sh;
  logic [DsrW:0]   rem_sub;
  logic            qbit;

  assign rem_sh  = {rem_q, quo_q[DvdW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign qbit    = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = qbit ? rem_sub[DsrW-1:0] : rem_sh[DsrW-1:0];
      quo_d = {quo_q[DvdW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/bvmon_dp.sv
`timescale 1ns / 1ps

module bvmon_dp import bvmon_pkg::*; #(
  parameter int unsigned Depth = 8,
  parameter int unsigned CntW  = 4,
  parameter int unsigned PtrW  = 3,
  parameter int unsigned SumW  = 19
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [AdcW-1:0]     adc_sample_i,
  input  dp_cmd_t             cmd_i,
  output logic                div_done_o,
  output logic [VoltW-1:0]    voltage_o,
  output logic [VoltW-1:0]    voltage_avg_o,
  output logic [LevelW-1:0]   level_o,
  output logic [CntW-1:0]     samples_held_o
);

  localparam int unsigned DvdW = SumW;
  localparam int unsigned DsrW = CntW;
  localparam int unsigned RecW = ProdMagW + CalRecipW;

  // configuration
  logic signed [VoltW-1:0] slope_q;
  logic [AdcW-1:0]         adc_ref_q;
  logic [VoltW-1:0]        volt_ref_q;
  logic [VoltW-1:0]        usb_lvl_q;
  logic [VoltW-1:0]        slow_lvl_q;
  logic [VoltW-1:0]        low_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q    <= 16'sd100;
      adc_ref_q  <= '0;
      volt_ref_q <= '0;
      usb_lvl_q  <= 16'd500;
      slow_lvl_q <= 16'd1100;
      low_lvl_q  <= 16'd1150;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLOPE_X100:      slope_q    <= signed'(cfg_wdata_i);
        REG_ADC_REF:         adc_ref_q  <= cfg_wdata_i[AdcW-1:0];
        REG_VOLT_REF:        volt_ref_q <= cfg_wdata_i;
        REG_USB_LEVEL:       usb_lvl_q  <= cfg_wdata_i;
        REG_SUPER_LOW_LEVEL: slow_lvl_q <= cfg_wdata_i;
        REG_LOW_LEVEL:       low_lvl_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [SumW-1:0] sum_q, sum_d;

  // payload
  logic [AdcW-1:0]         sample_q;
  logic signed [ProdW-1:0] prod_q;
  logic [VoltW-1:0]        cal_q;
  logic [VoltW-1:0]        volt_q;
  logic [VoltW-1:0]        old_q;
  logic [LevelW-1:0]       level_q;
  logic [VoltW-1:0]        hist [Depth];

  logic [VoltW-1:0]        out_volt_q, out_avg_q;
  logic [LevelW-1:0]       out_level_q;
  logic [CntW-1:0]         out_held_q;

  logic signed [AdcW:0]    diff;
  logic [ProdW-1:0]        prod_mag;
  logic                    prod_neg;
  logic [RecW-1:0]         rec_prod;
  logic                    div_start;
  logic [DvdW-1:0]         div_dvd;
  logic [DsrW-1:0]         div_dsr;
  logic [DvdW-1:0]         div_quo;
  logic [VoltW-1:0]        quo16;
  logic [VoltW-1:0]        volt_d;
  logic [LevelW-1:0]       level_d;
  logic                    full;

  assign diff     = signed'({1'b0, sample_q}) - signed'({1'b0, adc_ref_q});
  assign prod_neg = prod_q[ProdW-1];
  assign prod_mag = prod_neg ? (ProdW'(0) - prod_q) : prod_q;

  // divide by 100 as a reciprocal multiply on the magnitude
  assign rec_prod = RecW'(prod_mag[ProdMagW-1:0]) * RecW'(CalRecip);

  assign div_start = cmd_i.mean_start;
  assign div_dvd   = sum_q;
  assign div_dsr   = fill_q;

  bvmon_div #(
    .DvdW (DvdW),
    .DsrW (DsrW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done_o),
    .quotient_o (div_quo)
  );

  assign quo16  = div_quo[VoltW-1:0];
  assign volt_d = (prod_neg ? (VoltW'(0) - cal_q) : cal_q) + volt_ref_q;

  always_comb begin
    priority if (volt_q <= usb_lvl_q) begin
      level_d = LVL_USB;
    end else if (volt_q <= slow_lvl_q) begin
      level_d = LVL_SUPER_LOW;
    end else if (volt_q <= low_lvl_q) begin
      level_d = LVL_LOW;
    end else begin
      level_d = LVL_OK;
    end
  end

  assign full = (fill_q == CntW'(Depth));

  always_comb begin
    wptr_d = wptr_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (cmd_i.update) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (full) begin
        sum_d = sum_q - SumW'(old_q) + SumW'(volt_q);
      end else begin
        sum_d  = sum_q + SumW'(volt_q);
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= adc_sample_i;
      old_q    <= hist[wptr_q];
    end
    if (cmd_i.update) begin
      hist[wptr_q] <= volt_q;
      level_q      <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(slope_q) * ProdW'(diff);
    end
    if (cmd_i.cal_start) begin
      cal_q <= rec_prod[CalShift +: VoltW];
    end
    if (cmd_i.cal_done) begin
      volt_q <= volt_d;
    end
    if (cmd_i.out_load) begin
      out_volt_q  <= volt_q;
      out_avg_q   <= quo16;
      out_level_q <= level_q;
      out_held_q  <= fill_q;
    end
  end

  assign voltage_o      = out_volt_q;
  assign voltage_avg_o  = out_avg_q;
  assign level_o        = out_level_q;
  assign samples_held_o = out_held_q;

endmodule

FILE: rtl/core/bvmon_ctrl.sv
`timescale 1ns / 1ps

module bvmon_ctrl import bvmon_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    div_done_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CAL   = 3'd2;
  localparam logic [2:0] S_CALW  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_MEAN  = 3'd5;
  localparam logic [2:0] S_MEANW = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CAL;
      end
      S_CAL: begin
        cmd_o.cal_start = 1'b1;
        state_d         = S_CALW;
      end
      S_CALW: begin
        cmd_o.cal_done = 1'b1;
        state_d        = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_MEAN;
      end
      S_MEAN: begin
        cmd_o.mean_start = 1'b1;
        state_d          = S_MEANW;
      end
      S_MEANW: begin
        if (div_done_i) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/battery_voltage_monitor_core.sv
`timescale 1ns / 1ps

// Battery voltage monitor. Each 12-bit ADC transfer is calibrated to centivolts
// (slope_x100 * (sample - adc_ref) / 100, truncated toward zero, plus volt_ref,
// modulo 2^16), pushed into a ring of DEPTH entries, and one result transfer
// follows: the voltage, the truncated mean of the held entries, the level class
// (0 USB, 1 critically low, 2 low, 3 okay) and the entry count, saturating at
// DEPTH. One item is processed at a time; a new input is taken while the
// previous result still waits in the output register. Each item steps through
// load, multiply, calibrate, update, mean and output, and may wait on the output
// register; the mean comes from a radix-2 divider, one step per sum bit, and
// the divide by 100 is a reciprocal multiply.
// The user must write configuration registers through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while the block is idle; the block does not enforce this.

module battery_voltage_monitor_core import bvmon_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [AdcW-1:0]            adc_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [VoltW-1:0]           voltage_o,
  output logic [VoltW-1:0]           voltage_avg_o,
  output logic [LevelW-1:0]          level_o,
  output logic [$clog2(DEPTH+1)-1:0] samples_held_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SumW = VoltW + $clog2(DEPTH);

  dp_cmd_t cmd;
  logic    div_done;

  bvmon_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  bvmon_dp #(
    .Depth (DEPTH),
    .CntW  (CntW),
    .PtrW  (PtrW),
    .SumW  (SumW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .adc_sample_i   (adc_sample_i),
    .cmd_i          (cmd),
    .div_done_o     (div_done),
    .voltage_o      (voltage_o),
    .voltage_avg_o  (voltage_avg_o),
    .level_o        (level_o),
    .samples_held_o (samples_held_o)
  );

endmodule
